FILE: sv/assert_macros.svh
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with synchronous reset disable
`define ASSERT_CLKED(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  `ASSERT_CLKED(lbl, clk_s, rst_s, !(cond), msg)

`endif

FILE: sv/acbs_pkg.sv
// types and constants of the access conflict batch scheduler
`timescale 1ns / 1ps
package acbs_pkg;

  localparam int MASK_W      = 32;
  localparam int TASK_W      = 8;
  localparam int PHASE_W     = 2;
  localparam int BATCH_IDX_W = 4;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_PLACE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    RES_CLEAR    = 2'd0,
    RES_OVERFLOW = 2'd1,
    RES_PLACED   = 2'd2,
    RES_OPENED   = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      clear_counts;
    logic      rd_first;
    logic      rd_next;
    logic      step;
    logic      wr_merge;
    logic      wr_new;
    logic      set_res;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic phase_bad;
    logic no_batches;
    logic fit;
    logic last;
    logic full;
  } status_t;

endpackage

FILE: sv/acbs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module acbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/acbs_datapath.sv
// datapath: task registers, batch counts, union memory and result registers
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acbs_datapath #(
  parameter int NUM_PHASES          = 4,
  parameter int MAX_BATCHES         = 16,
  parameter int NUM_COMPONENT_TYPES = 32,
  parameter int NUM_RESOURCE_TYPES  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  acbs_pkg::cmd_t                          cmd,
  output acbs_pkg::status_t                       status,
  input  logic                                    req_type,
  input  logic [acbs_pkg::PHASE_W-1:0]            phase,
  input  logic [acbs_pkg::TASK_W-1:0]             task_id,
  input  logic [acbs_pkg::MASK_W-1:0]             comp_read_mask,
  input  logic [acbs_pkg::MASK_W-1:0]             comp_write_mask,
  input  logic [acbs_pkg::MASK_W-1:0]             res_read_mask,
  input  logic [acbs_pkg::MASK_W-1:0]             res_write_mask,
  output logic [acbs_pkg::TASK_W-1:0]             task_echo,
  output logic [acbs_pkg::PHASE_W-1:0]            phase_echo,
  output logic [acbs_pkg::BATCH_IDX_W-1:0]        batch_index,
  output logic                                    opened_batch,
  output logic                                    overflow
);
  import acbs_pkg::*;

  localparam int CMW   = NUM_COMPONENT_TYPES > MASK_W ? MASK_W : NUM_COMPONENT_TYPES;
  localparam int RMW   = NUM_RESOURCE_TYPES > MASK_W ? MASK_W : NUM_RESOURCE_TYPES;
  localparam int WW    = 2 * CMW + 2 * RMW;
  localparam int SLOTS = NUM_PHASES * MAX_BATCHES;
  localparam int AW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CNTW  = $clog2(MAX_BATCHES + 1);
  localparam int BW    = MAX_BATCHES > 1 ? $clog2(MAX_BATCHES) : 1;
  localparam int PIW   = NUM_PHASES > 1 ? $clog2(NUM_PHASES) : 1;

  logic                   req_r;
  logic [PHASE_W-1:0]     phase_r;
  logic [TASK_W-1:0]      task_r;
  logic [CMW-1:0]         cr_r, cw_r;
  logic [RMW-1:0]         rr_r, rw_r;
  logic [BW-1:0]          b;
  logic [CNTW-1:0]        count [NUM_PHASES];

  logic [TASK_W-1:0]      res_task;
  logic [PHASE_W-1:0]     res_phase;
  logic [BATCH_IDX_W-1:0] res_batch;
  logic                   res_opened;
  logic                   res_overflow;

  logic                   phase_ok;
  logic [PIW-1:0]         ph_idx;
  logic [CNTW-1:0]        n;
  logic [CNTW-1:0]        b_inc;
  logic [AW-1:0]          base;
  logic [AW-1:0]          raddr, waddr;
  logic                   we, re;
  logic [WW-1:0]          wdata, rdata;
  logic [CMW-1:0]         ucr, ucw;
  logic [RMW-1:0]         urr, urw;
  logic                   clash_c, clash_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      phase_r <= phase;
      task_r  <= task_id;
      cr_r    <= comp_read_mask[CMW-1:0];
      cw_r    <= comp_write_mask[CMW-1:0];
      rr_r    <= res_read_mask[RMW-1:0];
      rw_r    <= res_write_mask[RMW-1:0];
    end
    if (cmd.rd_first) begin
      b <= '0;
    end else if (cmd.step) begin
      b <= b + 1'b1;
    end
  end

  assign phase_ok = 32'(phase_r) < 32'(NUM_PHASES);
  assign ph_idx   = PIW'(phase_r);
  assign n        = phase_ok ? count[ph_idx] : '0;
  assign b_inc    = CNTW'(b) + 1'b1;
  assign base     = AW'(ph_idx) * AW'(MAX_BATCHES);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PHASES; i++) begin
        count[i] <= '0;
      end
    end else if (cmd.clear_counts) begin
      for (int i = 0; i < NUM_PHASES; i++) begin
        count[i] <= '0;
      end
    end else if (cmd.wr_new) begin
      count[ph_idx] <= n + 1'b1;
    end
  end

  assign {ucr, ucw, urr, urw} = rdata;

  assign re    = cmd.rd_first | cmd.rd_next;
  assign raddr = cmd.rd_next ? base + AW'(b_inc) : base;
  assign we    = cmd.wr_merge | cmd.wr_new;
  assign waddr = cmd.wr_new ? base + AW'(n) : base + AW'(b);
  assign wdata = cmd.wr_new ? {cr_r, cw_r, rr_r, rw_r}
                            : {cr_r | ucr, cw_r | ucw, rr_r | urr, rw_r | urw};

  acbs_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS)
  ) u_union_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // conflict when one side writes a type the other touches
  assign clash_c = |((cw_r & (ucr | ucw)) | (cr_r & ucw));
  assign clash_r = |((rw_r & (urr | urw)) | (rr_r & urw));

  assign status.is_clear   = (req_r == REQ_CLEAR);
  assign status.phase_bad  = !phase_ok;
  assign status.no_batches = (n == '0);
  assign status.fit        = !clash_c && !clash_r;
  assign status.last       = (b_inc >= n);
  assign status.full       = (n >= CNTW'(MAX_BATCHES));

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      unique case (cmd.res_kind)
        RES_CLEAR: begin
          res_task     <= '0;
          res_phase    <= '0;
          res_batch    <= '0;
          res_opened   <= 1'b0;
          res_overflow <= 1'b0;
        end
        RES_OVERFLOW: begin
          res_task     <= task_r;
          res_phase    <= phase_r;
          res_batch    <= '0;
          res_opened   <= 1'b0;
          res_overflow <= 1'b1;
        end
        RES_PLACED: begin
          res_task     <= task_r;
          res_phase    <= phase_r;
          res_batch    <= BATCH_IDX_W'(b);
          res_opened   <= 1'b0;
          res_overflow <= 1'b0;
        end
        RES_OPENED: begin
          res_task     <= task_r;
          res_phase    <= phase_r;
          res_batch    <= BATCH_IDX_W'(n);
          res_opened   <= 1'b1;
          res_overflow <= 1'b0;
        end
      endcase
    end
    if (cmd.out_load) begin
      task_echo    <= res_task;
      phase_echo   <= res_phase;
      batch_index  <= res_batch;
      opened_batch <= res_opened;
      overflow     <= res_overflow;
    end
  end

  `ASSERT_CLKED(a_new_only_with_room, clk, rst, cmd.wr_new |-> !status.full, "open while full")
  `ASSERT_NEVER(a_merge_needs_fit, clk, rst, cmd.wr_merge && !status.fit, "merge into conflict")

endmodule

FILE: sv/acbs_ctrl.sv
// controller state machine of the scheduler
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  acbs_pkg::status_t status,
  output acbs_pkg::cmd_t    cmd
);
  import acbs_pkg::*;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (status.is_clear) begin
          cmd.clear_counts = 1'b1;
          cmd.set_res      = 1'b1;
          cmd.res_kind     = RES_CLEAR;
          state_next       = S_OUT;
        end else if (status.phase_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_OVERFLOW;
          state_next   = S_OUT;
        end else if (status.no_batches) begin
          cmd.wr_new   = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_OPENED;
          state_next   = S_OUT;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = S_CMP;
        end
      end
      S_CMP: begin
        cmd.rd_next = 1'b1;
        priority if (status.fit) begin
          cmd.wr_merge = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_PLACED;
          state_next   = S_OUT;
        end else if (!status.last) begin
          cmd.step = 1'b1;
        end else if (status.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_OVERFLOW;
          state_next   = S_OUT;
        end else begin
          cmd.wr_new   = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_OPENED;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_CLKED(a_accept_to_eval, clk, rst, (in_valid && in_ready) |=> (state == S_EVAL), "accepted beat not evaluated")
  `ASSERT_CLKED(a_stall_holds_result, clk, rst, (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT), "result dropped under stall")
  `ASSERT_NEVER(a_single_write, clk, rst, cmd.wr_merge && cmd.wr_new, "merge and open in one cycle")
  `ASSERT_CLKED(a_load_sets_valid, clk, rst, cmd.out_load |=> out_valid, "result beat not presented")

endmodule

FILE: sv/access_conflict_batch_scheduler.sv
// Access conflict batch scheduler: greedy first-fit placement of tasks into batches.
// Input channel (in_valid/in_ready) takes one beat per request: req_type 0 clears
// all batch counts, req_type 1 places a task of the given phase with its masks.
// Output channel (out_valid/out_ready) returns exactly one beat per request with
// the task and phase echoed (zeros for a clear), the batch index, and the opened and overflow flags.
// A clear, an out-of-range phase, or a placement into a phase with no open batch goes
// straight from evaluation to the output state; any other placement probes the open
// batches of its phase one per cycle from the union memory and merges into the first
// that fits, else opens a new batch, or overflows when MAX_BATCHES are already open.
// The next beat is taken in the cycle after the result enters the output register.
// A new beat is taken once the previous result sits in the output register, so the
// input side keeps moving while the receiver stalls on a single pending result;
// a second result waits inside the block and holds in_ready low.
// Reset (rst, synchronous) zeroes all batch counts and drops out_valid; the union
// memory needs no clearing since only entries of open batches are read.
`timescale 1ns / 1ps
module access_conflict_batch_scheduler #(
  parameter int NUM_PHASES          = 4,
  parameter int MAX_BATCHES         = 16,
  parameter int NUM_COMPONENT_TYPES = 32,
  parameter int NUM_RESOURCE_TYPES  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [acbs_pkg::PHASE_W-1:0]     phase,
  input  logic [acbs_pkg::TASK_W-1:0]      task_id,
  input  logic [acbs_pkg::MASK_W-1:0]      comp_read_mask,
  input  logic [acbs_pkg::MASK_W-1:0]      comp_write_mask,
  input  logic [acbs_pkg::MASK_W-1:0]      res_read_mask,
  input  logic [acbs_pkg::MASK_W-1:0]      res_write_mask,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [acbs_pkg::TASK_W-1:0]      task_echo,
  output logic [acbs_pkg::PHASE_W-1:0]     phase_echo,
  output logic [acbs_pkg::BATCH_IDX_W-1:0] batch_index,
  output logic                             opened_batch,
  output logic                             overflow
);
  import acbs_pkg::*;

  cmd_t    cmd;
  status_t status;

  acbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  acbs_datapath #(
    .NUM_PHASES          (NUM_PHASES),
    .MAX_BATCHES         (MAX_BATCHES),
    .NUM_COMPONENT_TYPES (NUM_COMPONENT_TYPES),
    .NUM_RESOURCE_TYPES  (NUM_RESOURCE_TYPES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req_type),
    .phase           (phase),
    .task_id         (task_id),
    .comp_read_mask  (comp_read_mask),
    .comp_write_mask (comp_write_mask),
    .res_read_mask   (res_read_mask),
    .res_write_mask  (res_write_mask),
    .task_echo       (task_echo),
    .phase_echo      (phase_echo),
    .batch_index     (batch_index),
    .opened_batch    (opened_batch),
    .overflow        (overflow)
  );

endmodule

FILE: test/tb_access_conflict_batch_scheduler.sv
// testbench for the access conflict batch scheduler: directed and random plans, self-checked
`timescale 1ns / 1ps
module tb_access_conflict_batch_scheduler;
  import acbs_pkg::*;

  localparam int NUM_PHASES   = 4;
  localparam int MAX_BATCHES  = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = MAX_BATCHES + 8;

  typedef struct {
    logic              req;
    logic [PHASE_W-1:0] ph;
    logic [TASK_W-1:0]  id;
    logic [MASK_W-1:0]  cr;
    logic [MASK_W-1:0]  cw;
    logic [MASK_W-1:0]  rr;
    logic [MASK_W-1:0]  rw;
  } sched_req_t;

  typedef struct packed {
    logic [TASK_W-1:0]      task_id;
    logic [PHASE_W-1:0]     phase;
    logic [BATCH_IDX_W-1:0] batch;
    logic                   opened;
    logic                   ovf;
  } placement_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   req_type;
  logic [PHASE_W-1:0]     phase;
  logic [TASK_W-1:0]      task_id;
  logic [MASK_W-1:0]      comp_read_mask;
  logic [MASK_W-1:0]      comp_write_mask;
  logic [MASK_W-1:0]      res_read_mask;
  logic [MASK_W-1:0]      res_write_mask;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [TASK_W-1:0]      task_echo;
  logic [PHASE_W-1:0]     phase_echo;
  logic [BATCH_IDX_W-1:0] batch_index;
  logic                   opened_batch;
  logic                   overflow;

  // batch unions per phase and batch, open batch count per phase
  logic [MASK_W-1:0] union_cr [NUM_PHASES][MAX_BATCHES];
  logic [MASK_W-1:0] union_cw [NUM_PHASES][MAX_BATCHES];
  logic [MASK_W-1:0] union_rr [NUM_PHASES][MAX_BATCHES];
  logic [MASK_W-1:0] union_rw [NUM_PHASES][MAX_BATCHES];
  int unsigned       batches_open [NUM_PHASES];

  placement_t pending_placements[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct;
  int         recv_stall_pct;
  logic       holding_off = 1'b0;
  event       hold_off_ev;

  access_conflict_batch_scheduler #(
    .NUM_PHASES(NUM_PHASES),
    .MAX_BATCHES(MAX_BATCHES),
    .NUM_COMPONENT_TYPES(32),
    .NUM_RESOURCE_TYPES(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .phase(phase),
    .task_id(task_id),
    .comp_read_mask(comp_read_mask),
    .comp_write_mask(comp_write_mask),
    .res_read_mask(res_read_mask),
    .res_write_mask(res_write_mask),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .task_echo(task_echo),
    .phase_echo(phase_echo),
    .batch_index(batch_index),
    .opened_batch(opened_batch),
    .overflow(overflow)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic has_conflict(input logic [MASK_W-1:0] rd, wr, u_rd, u_wr);
    return ((wr & (u_rd | u_wr)) | (rd & u_wr)) != '0;
  endfunction

  function automatic placement_t schedule_task(input sched_req_t item);
    placement_t  res;
    int unsigned n;
    int unsigned b;
    res = '0;
    if (item.req == REQ_CLEAR) begin
      foreach (batches_open[p]) batches_open[p] = 0;
      return res;
    end
    res.task_id = item.id;
    res.phase   = item.ph;
    if (item.ph >= NUM_PHASES) begin
      res.ovf = 1'b1;
      return res;
    end
    n = batches_open[item.ph];
    for (b = 0; b < n; b++) begin
      if (!has_conflict(item.cr, item.cw, union_cr[item.ph][b], union_cw[item.ph][b]) &&
          !has_conflict(item.rr, item.rw, union_rr[item.ph][b], union_rw[item.ph][b])) begin
        union_cr[item.ph][b] |= item.cr;
        union_cw[item.ph][b] |= item.cw;
        union_rr[item.ph][b] |= item.rr;
        union_rw[item.ph][b] |= item.rw;
        res.batch = b[BATCH_IDX_W-1:0];
        return res;
      end
    end
    if (n >= MAX_BATCHES) begin
      res.ovf = 1'b1;
      return res;
    end
    union_cr[item.ph][n] = item.cr;
    union_cw[item.ph][n] = item.cw;
    union_rr[item.ph][n] = item.rr;
    union_rw[item.ph][n] = item.rw;
    batches_open[item.ph] = n + 1;
    res.batch  = n[BATCH_IDX_W-1:0];
    res.opened = 1'b1;
    return res;
  endfunction

  function automatic sched_req_t place_req(input logic [PHASE_W-1:0] ph,
                                           input logic [TASK_W-1:0] id,
                                           input logic [MASK_W-1:0] cr, cw, rr, rw);
    sched_req_t item;
    item.req = REQ_PLACE;
    item.ph  = ph;
    item.id  = id;
    item.cr  = cr;
    item.cw  = cw;
    item.rr  = rr;
    item.rw  = rw;
    return item;
  endfunction

  function automatic sched_req_t clear_req();
    sched_req_t item;
    item     = place_req(PHASE_W'($urandom), TASK_W'($urandom), $urandom, $urandom,
                         $urandom, $urandom);
    item.req = REQ_CLEAR;
    return item;
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return $urandom & $urandom & $urandom & $urandom;
    endcase
  endfunction

  task automatic offer_request(input sched_req_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= item.req;
    phase           <= item.ph;
    task_id         <= item.id;
    comp_read_mask  <= item.cr;
    comp_write_mask <= item.cw;
    res_read_mask   <= item.rr;
    res_write_mask  <= item.rw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_placements.insert(pending_placements.size(), schedule_task(item));
  endtask

  task automatic test_conflict_rules();
    offer_request(clear_req());
    offer_request(place_req(2'd0, 8'h01, 32'h1, '0, '0, '0));
    offer_request(place_req(2'd0, 8'h02, 32'h1, '0, '0, '0));
    offer_request(place_req(2'd0, 8'h03, '0, 32'h1, '0, '0));
    offer_request(place_req(2'd0, 8'h04, 32'h1, '0, '0, '0));
    offer_request(place_req(2'd0, 8'h05, '0, '0, 32'h2, '0));
    offer_request(place_req(2'd0, 8'h06, '0, '0, '0, 32'h2));
    offer_request(place_req(2'd0, 8'h07, '0, '0, 32'h2, '0));
    offer_request(place_req(2'd1, 8'hff, '1, '1, '1, '1));
  endtask

  task automatic test_batch_exhaustion();
    int i;
    for (i = 0; i <= MAX_BATCHES; i++)
      offer_request(place_req(2'd3, TASK_W'(8'h80 + i), '0, '0, '0, 32'h8000_0000));
    offer_request(clear_req());
    offer_request(place_req(2'd3, 8'h00, '0, '0, '0, 32'h8000_0000));
  endtask

  task automatic test_random_plans(input int n_items, input int idle_pct, input int stall_pct);
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    offer_request(clear_req());
    for (i = 1; i < n_items; i++) begin
      if ($urandom_range(39) == 0)
        offer_request(clear_req());
      else
        offer_request(place_req(PHASE_W'($urandom), TASK_W'($urandom), rand_mask(),
                                rand_mask(), rand_mask(), rand_mask()));
    end
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_off_ev;
    for (i = 0; i < 40; i++)
      offer_request(place_req(PHASE_W'($urandom_range(1)), TASK_W'($urandom), rand_mask(),
                              rand_mask(), rand_mask(), rand_mask()));
  endtask

  // receiver hold-off, counted here
  always begin
    @(hold_off_ev);
    holding_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding_off = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= !holding_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input int unsigned exp_v, act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : check_results
    placement_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_placements.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none actual task %0h", $time, task_echo);
      end else begin
        exp_res = pending_placements.pop_front();
        check_field("task_echo", 32'(exp_res.task_id), 32'(task_echo));
        check_field("phase_echo", 32'(exp_res.phase), 32'(phase_echo));
        check_field("batch_index", 32'(exp_res.batch), 32'(batch_index));
        check_field("opened_batch", 32'(exp_res.opened), 32'(opened_batch));
        check_field("overflow", 32'(exp_res.ovf), 32'(overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    req_type        = REQ_CLEAR;
    phase           = '0;
    task_id         = '0;
    comp_read_mask  = '0;
    comp_write_mask = '0;
    res_read_mask   = '0;
    res_write_mask  = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    foreach (batches_open[p]) batches_open[p] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_conflict_rules();
    test_batch_exhaustion();
    test_random_plans(100, 0, 0);
    test_random_plans(100, 64, 0);
    test_random_plans(100, 0, 64);
    test_random_plans(100, 24, 24);
    test_backpressure();

    @(negedge clk);
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/acbs_pkg.sv
sv/acbs_ram.sv
sv/acbs_datapath.sv
sv/acbs_ctrl.sv
sv/access_conflict_batch_scheduler.sv
test/tb_access_conflict_batch_scheduler.sv
